// ===== rtl/core/ssc_pkg.sv =====
// Package for the segmented spike compaction unit.
// Holds sizes, the item codes and the structs shared by the core modules.
// No dependencies.
package ssc_pkg;

    localparam int unsigned NEURONS    = 4096;
    localparam int unsigned ENTRIES    = 65536;

    localparam int unsigned NEURON_W   = 12;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned TOTAL_W    = 17;
    localparam int unsigned FLAG_DEPTH = 1 << NEURON_W;

    // Counter bound: the entry bound, clipped to what the position field holds.
    localparam int unsigned CAP = (ENTRIES < (1 << POS_W)) ? ENTRIES : (1 << POS_W);
    localparam logic [POS_W-1:0]   POS_MAX   = POS_W'(CAP - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(CAP);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_SEND  = 1'b1
    } op_t;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [NEURON_W-1:0] addr;
        logic                wr_data;
    } flag_req_t;

    typedef struct packed {
        logic ok;
        logic last_in_segment;
        logic last_of_list;
    } entry_t;

    typedef struct packed {
        logic               active;
        logic [POS_W-1:0]   position_in_segment;
        logic [POS_W-1:0]   slot;
        logic               segment_end;
        logic [TOTAL_W-1:0] active_total;
    } result_t;

    function automatic logic neuron_ok(input logic [NEURON_W-1:0] n);
        return 32'(n) < NEURONS;
    endfunction

endpackage

// ===== rtl/core/ssc_if.sv =====
// Handshake channel interfaces of the segmented spike compaction unit.
// Depends on ssc_pkg for the field widths.
interface ssc_in_if import ssc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op;
    logic [NEURON_W-1:0] neuron;
    logic                flag;
    logic                last_in_segment;
    logic                last_of_list;

    modport source (output valid, op, neuron, flag, last_in_segment, last_of_list,
                    input ready);
    modport sink   (input valid, op, neuron, flag, last_in_segment, last_of_list,
                    output ready);
endinterface

interface ssc_out_if import ssc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               active;
    logic [POS_W-1:0]   position_in_segment;
    logic [POS_W-1:0]   slot;
    logic               segment_end;
    logic [TOTAL_W-1:0] active_total;

    modport source (output valid, active, position_in_segment, slot, segment_end,
                    active_total, input ready);
    modport sink   (input valid, active, position_in_segment, slot, segment_end,
                    active_total, output ready);
endinterface

// ===== rtl/core/segmented_spike_compaction_unit.sv =====
// Top level of the segmented spike compaction unit.
// Depends on ssc_pkg, ssc_if, ssc_flag_store and ssc_seq.

// The unit takes one item per cycle on spike_in while spike_in.ready is high and
// returns one result per sending entry on result. A write item (op = 0) sets or
// clears the fired flag of its neuron and returns nothing; a sending entry
// (op = 1) reads its neuron's flag and returns the flag, the entry's position in
// its segment, its slot in the compacted active list and, at a segment end, the
// running active total. The flags live in a RAM with a registered read: the entry
// waits in a holding register for the flag, and the result register then holds
// the finished result, so a new transfer is taken in every cycle unless the
// result side stalls. A write is seen by any sending entry that follows it. After
// reset the unit sweeps the flag RAM to zero, one neuron a cycle, and holds
// spike_in.ready low until the sweep is done. Counters restart at segment and
// list ends and saturate at the entry bound.
module segmented_spike_compaction_unit import ssc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    ssc_in_if.sink     spike_in,
    ssc_out_if.source  result
);

    logic      busy;
    logic      go;
    logic      accept;
    logic      is_send;
    logic      advance;
    logic      rd_flag;
    logic      out_valid;
    flag_req_t flag_req;
    result_t   res;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    entry_t    s1_entry_reg;

    // The holding stage can take an entry when it is empty or moves on this cycle.
    assign spike_in.ready = !busy && (!s1_valid_reg || go);
    assign accept         = spike_in.valid && spike_in.ready;
    assign is_send        = (spike_in.op == OP_SEND);
    assign advance        = s1_valid_reg && go;

    // Reads and writes go to the RAM at the transfer itself, so a write lands
    // before the read of any later entry.
    always_comb
    begin
        flag_req.rd_en   = accept && is_send;
        flag_req.wr_en   = accept && !is_send && neuron_ok(spike_in.neuron);
        flag_req.addr    = spike_in.neuron;
        flag_req.wr_data = spike_in.flag;
    end

    always_comb
    begin
        if (accept && is_send)
        begin
            s1_valid_next = 1'b1;
        end
        else if (go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_send)
        begin
            s1_entry_reg.ok              <= neuron_ok(spike_in.neuron);
            s1_entry_reg.last_in_segment <= spike_in.last_in_segment;
            s1_entry_reg.last_of_list    <= spike_in.last_of_list;
        end
    end

    ssc_flag_store u_flag_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (flag_req),
        .rd_flag (rd_flag),
        .busy    (busy)
    );

    ssc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .entry     (s1_entry_reg),
        .rd_flag   (rd_flag),
        .out_ready (result.ready),
        .go        (go),
        .out_valid (out_valid),
        .result    (res)
    );

    assign result.valid               = out_valid;
    assign result.active              = res.active;
    assign result.position_in_segment = res.position_in_segment;
    assign result.slot                = res.slot;
    assign result.segment_end         = res.segment_end;
    assign result.active_total        = res.active_total;

`ifndef SYNTHESIS
    // No transfer is taken while the flag RAM is being cleared.
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !spike_in.ready)
        else $error("input ready while flag RAM clears");

    // The active total is only reported when a segment closes.
    a_total_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.segment_end) |-> (result.active_total == '0))
        else $error("active total outside segment end");

    // An inactive entry gets no slot.
    a_slot_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.active) |-> (result.slot == '0))
        else $error("slot given to inactive entry");

    // An entry that finds the result side free reaches it in the next cycle.
    a_entry_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !result.valid) |=> result.valid)
        else $error("held entry did not reach result register");
`endif

endmodule

// ===== rtl/core/ssc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ssc_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ssc_flag_store.sv =====
// Fired flag store: one flag per neuron in a RAM, with a clearing sweep after reset.
// Depends on ssc_pkg and ssc_ram.
module ssc_flag_store import ssc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  flag_req_t req,
    output logic      rd_flag,
    output logic      busy
);

    logic                busy_reg;
    logic                busy_next;
    logic [NEURON_W-1:0] clr_addr_reg;
    logic [NEURON_W-1:0] clr_addr_next;
    logic                ram_we;
    logic [NEURON_W-1:0] ram_waddr;
    logic                ram_wdata;

    // The sweep writes zero to one address a cycle until the last one is done.
    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + NEURON_W'(1);
            if (clr_addr_reg == '1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        ram_we    = busy_reg ? 1'b1 : req.wr_en;
        ram_waddr = busy_reg ? clr_addr_reg : req.addr;
        ram_wdata = busy_reg ? 1'b0 : req.wr_data;
    end

    ssc_ram #(
        .WIDTH (1),
        .DEPTH (FLAG_DEPTH)
    ) u_flag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req.rd_en),
        .raddr (req.addr),
        .rdata (rd_flag)
    );

    assign busy = busy_reg;

endmodule

// ===== rtl/core/ssc_seq.sv =====
// Segment and list counters with the result register of the compaction unit.
// Depends on ssc_pkg.
module ssc_seq import ssc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  entry_t  entry,
    input  logic    rd_flag,
    input  logic    out_ready,
    output logic    go,
    output logic    out_valid,
    output result_t result
);

    logic [POS_W-1:0]   seg_pos_reg;
    logic [POS_W-1:0]   seg_pos_next;
    logic [TOTAL_W-1:0] count_reg;
    logic [TOTAL_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            result_reg;
    result_t            result_next;

    logic               act;
    logic               seg_end;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   slot_clip;
    logic [TOTAL_W-1:0] total;

    assign go = !out_valid_reg || out_ready;

    always_comb
    begin
        act       = entry.ok & rd_flag;
        seg_end   = entry.last_in_segment | entry.last_of_list;
        pos       = (seg_pos_reg > POS_MAX) ? POS_MAX : seg_pos_reg;
        slot_clip = (count_reg > TOTAL_W'(POS_MAX)) ? POS_MAX : count_reg[POS_W-1:0];
        total     = (act && (count_reg < TOTAL_MAX)) ? count_reg + TOTAL_W'(1) : count_reg;

        result_next.active              = act;
        result_next.position_in_segment = pos;
        result_next.slot                = act ? slot_clip : '0;
        result_next.segment_end         = seg_end;
        result_next.active_total        = seg_end ? total : '0;

        seg_pos_next = seg_pos_reg;
        count_next   = count_reg;
        if (advance)
        begin
            seg_pos_next = seg_end ? '0 : ((pos < POS_MAX) ? pos + POS_W'(1) : POS_MAX);
            count_next   = entry.last_of_list ? '0 : total;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_pos_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_pos_reg   <= seg_pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== tb/sv/ssc_compaction_monitor.sv =====
`timescale 1ns / 1ps
// Scoreboard for the segmented spike compaction unit: predicts every result
// from the transfers it sees on spike_in and checks the transfers on result.
// Depends on ssc_pkg and the channel interfaces in ssc_if.
module ssc_compaction_monitor import ssc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    ssc_in_if    spike_in,
    ssc_out_if   result,
    output int   misses,
    output int   awaited
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the block's state.
    logic               fired [FLAG_DEPTH];
    logic [POS_W-1:0]   seg_offset;
    logic [TOTAL_W-1:0] list_actives;
    result_t            awaited_results [$];
    int                 miss_total;

    task automatic note_miss(input string what, input logic [31:0] want,
                             input logic [31:0] got);
        miss_total++;
        if (miss_total <= REPORT_LIMIT)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t            want;
        result_t            got;
        logic               act;
        logic               closing;
        logic [TOTAL_W-1:0] total;
        if (!rst_n)
        begin
            for (int i = 0; i < FLAG_DEPTH; i++)
            begin
                fired[i] = 1'b0;
            end
            seg_offset   = '0;
            list_actives = '0;
            awaited_results.delete();
            miss_total   = 0;
            misses  <= 0;
            awaited <= 0;
        end
        else
        begin
            // Results first: an entry taken at this edge cannot have its result yet.
            if (result.valid && result.ready)
            begin
                got.active              = result.active;
                got.position_in_segment = result.position_in_segment;
                got.slot                = result.slot;
                got.segment_end         = result.segment_end;
                got.active_total        = result.active_total;
                if (awaited_results.size() == 0)
                begin
                    miss_total++;
                    if (miss_total <= REPORT_LIMIT)
                    begin
                        $display("%0t: result transfer with nothing pending, got %p",
                                 $realtime, got);
                    end
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.active !== want.active)
                        note_miss("active", 32'(want.active), 32'(got.active));
                    if (got.position_in_segment !== want.position_in_segment)
                        note_miss("position_in_segment", 32'(want.position_in_segment),
                                  32'(got.position_in_segment));
                    if (got.slot !== want.slot)
                        note_miss("slot", 32'(want.slot), 32'(got.slot));
                    if (got.segment_end !== want.segment_end)
                        note_miss("segment_end", 32'(want.segment_end),
                                  32'(got.segment_end));
                    if (got.active_total !== want.active_total)
                        note_miss("active_total", 32'(want.active_total),
                                  32'(got.active_total));
                end
            end

            if (spike_in.valid && spike_in.ready)
            begin
                if (spike_in.op == OP_WRITE)
                begin
                    if (int'(spike_in.neuron) < NEURONS)
                        fired[spike_in.neuron] = spike_in.flag;
                end
                else
                begin
                    act = (int'(spike_in.neuron) < NEURONS) ? fired[spike_in.neuron] : 1'b0;
                    closing = spike_in.last_in_segment || spike_in.last_of_list;
                    want.active = act;
                    want.position_in_segment = (seg_offset > POS_MAX) ? POS_MAX : seg_offset;
                    if (!act)
                        want.slot = '0;
                    else if (list_actives > TOTAL_W'(POS_MAX))
                        want.slot = POS_MAX;
                    else
                        want.slot = POS_W'(list_actives);
                    total = (act && list_actives < TOTAL_MAX) ? list_actives + 1'b1
                                                              : list_actives;
                    want.segment_end  = closing;
                    want.active_total = closing ? total : '0;
                    awaited_results.push_back(want);

                    if (closing)
                        seg_offset = '0;
                    else if (want.position_in_segment < POS_MAX)
                        seg_offset = want.position_in_segment + 1'b1;
                    else
                        seg_offset = POS_MAX;
                    list_actives = spike_in.last_of_list ? '0 : total;
                end
            end

            misses  <= miss_total;
            awaited <= awaited_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the segmented spike compaction testbench: clock, reset, stimulus
// and verdict. Depends on ssc_pkg, ssc_if, the unit and ssc_compaction_monitor.
module tb_top;
    import ssc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_ITEMS = 1100;
    // The unit clears its flag RAM after reset with spike_in.ready low for the
    // whole sweep, so the watchdog must sit well above the sweep's length.
    localparam int STALL_LIMIT  = 20000;
    // The result leaves through the holding and result registers; a few more cycles are
    // waited at the end so that a stray result still gets caught.
    localparam int DRAIN_CYCLES = 8;
    localparam int HOT_NEURONS  = 16;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic sink_ready = 1'b0;
    int   misses;
    int   awaited;
    int   quiet_cycles    = 0;
    int   burst_left      = 0;
    int   random_sent     = 0;
    int   sink_mode       = 0;
    int   sink_phase_left = 0;
    int   sink_tick       = 0;
    logic [NEURON_W-1:0] hot_pool [HOT_NEURONS];

    ssc_in_if  spike_in ();
    ssc_out_if result ();

    assign result.ready = sink_ready;

    segmented_spike_compaction_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .spike_in (spike_in),
        .result   (result)
    );

    ssc_compaction_monitor compaction_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .spike_in (spike_in),
        .result   (result),
        .misses   (misses),
        .awaited  (awaited)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // The result side runs through phases of random length. Each phase has its
    // own stall style: always ready, coin flip, mostly stalled, or a fixed
    // duty pattern. The phase lengths do not line up with the sender's bursts,
    // so stalls land on every stage of the pipeline.
    always @(posedge clk)
    begin
        sink_tick <= sink_tick + 1;
        if (sink_phase_left == 0)
        begin
            sink_mode       <= $urandom_range(0, 3);
            sink_phase_left <= $urandom_range(20, 300);
        end
        else
        begin
            sink_phase_left <= sink_phase_left - 1;
        end
        case (sink_mode)
            0:       sink_ready <= 1'b1;
            1:       sink_ready <= 1'($urandom_range(0, 1));
            2:       sink_ready <= ($urandom_range(0, 3) == 0);
            default: sink_ready <= (sink_tick % 5) != 0;
        endcase
    end

    // Watchdog: a run that goes too long without any transfer on either
    // channel is a hang.
    always @(posedge clk)
    begin
        if ((spike_in.valid && spike_in.ready) || (result.valid && result.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one item and holds it until the transfer happens. The task is
    // entered right after a rising edge, so ready is read as it was at the
    // edge. Valid stays high when the next item follows at once.
    task automatic offer(input op_t op, input logic [NEURON_W-1:0] neuron,
                         input logic flag, input logic seg_last, input logic list_last);
        spike_in.valid           <= 1'b1;
        spike_in.op              <= op;
        spike_in.neuron          <= neuron;
        spike_in.flag            <= flag;
        spike_in.last_in_segment <= seg_last;
        spike_in.last_of_list    <= list_last;
        do
            @(posedge clk);
        while (!spike_in.ready);
    endtask

    // Drops valid for a number of cycles.
    task automatic rest(input int cycles);
        spike_in.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Called before each item. The sender works in bursts: mostly short ones,
    // now and then a long stretch without any gap.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 24);
            gap = $urandom_range(1, 12);
            rest(gap);
        end
        burst_left--;
    endtask

    task automatic feed(input op_t op, input logic [NEURON_W-1:0] neuron,
                        input logic flag, input logic seg_last, input logic list_last);
        pace();
        offer(op, neuron, flag, seg_last, list_last);
        random_sent++;
    endtask

    // Most traffic goes to a small pool of neurons so that reads find flags
    // that were written; the rest hits the index extremes or any neuron.
    function automatic logic [NEURON_W-1:0] pick_neuron();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return hot_pool[$urandom_range(0, HOT_NEURONS - 1)];
        else if (roll == 7)
            return ($urandom_range(0, 1) == 1) ? NEURON_W'(FLAG_DEPTH - 1) : '0;
        else
            return NEURON_W'($urandom_range(0, FLAG_DEPTH - 1));
    endfunction

    initial
    begin
        int segs;
        int len;
        spike_in.valid           = 1'b0;
        spike_in.op              = OP_WRITE;
        spike_in.neuron          = '0;
        spike_in.flag            = 1'b0;
        spike_in.last_in_segment = 1'b0;
        spike_in.last_of_list    = 1'b0;
        for (int i = 0; i < HOT_NEURONS; i++)
        begin
            hot_pool[i] = NEURON_W'($urandom_range(0, FLAG_DEPTH - 1));
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, back to back. A neuron read before any write must
        // come back clear, and a read right after a write must see it.
        offer(OP_SEND,  '0,         1'b0, 1'b0, 1'b0);
        offer(OP_WRITE, '0,         1'b1, 1'b0, 1'b0);
        offer(OP_SEND,  '0,         1'b0, 1'b0, 1'b0);
        // Segment marks on a write item are ignored.
        offer(OP_WRITE, 12'hFFF,    1'b1, 1'b1, 1'b1);
        offer(OP_SEND,  12'hFFF,    1'b0, 1'b1, 1'b0);
        offer(OP_SEND,  12'h001,    1'b0, 1'b0, 1'b0);
        // End of list alone also closes the segment.
        offer(OP_SEND,  '0,         1'b0, 1'b0, 1'b1);
        offer(OP_WRITE, '0,         1'b0, 1'b0, 1'b0);
        offer(OP_SEND,  '0,         1'b0, 1'b1, 1'b1);
        offer(OP_WRITE, 12'hAAA,    1'b1, 1'b0, 1'b0);
        offer(OP_WRITE, 12'h555,    1'b1, 1'b0, 1'b0);
        offer(OP_SEND,  12'hAAA,    1'b0, 1'b0, 1'b0);
        offer(OP_SEND,  12'h555,    1'b0, 1'b1, 1'b0);
        offer(OP_SEND,  12'hFFF,    1'b0, 1'b0, 1'b0);
        offer(OP_SEND,  12'h001,    1'b0, 1'b1, 1'b0);
        offer(OP_SEND,  12'hAAA,    1'b0, 1'b0, 1'b1);
        offer(OP_WRITE, 12'hFFF,    1'b0, 1'b0, 1'b0);
        offer(OP_SEND,  12'hFFF,    1'b0, 1'b0, 1'b1);

        // Random part. Most of it is well-formed lists of segments with flag
        // writes mixed in; about one round in ten is a loose item with random
        // marks, which breaks lists at odd places.
        while (random_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                feed(op_t'($urandom_range(0, 1)), NEURON_W'($urandom_range(0, FLAG_DEPTH - 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            end
            else
            begin
                segs = $urandom_range(1, 5);
                for (int s = 0; s < segs; s++)
                begin
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(1, 8);
                    for (int e = 0; e < len; e++)
                    begin
                        while ($urandom_range(0, 2) == 0)
                        begin
                            feed(OP_WRITE, pick_neuron(), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                        end
                        feed(OP_SEND, pick_neuron(), 1'($urandom_range(0, 1)),
                             e == len - 1, (s == segs - 1) && (e == len - 1));
                    end
                end
            end
        end

        // Let the pipeline empty, then give it a few more cycles.
        rest(1);
        while (awaited != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (misses == 0 && awaited == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
